[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Depends on nothing; users provide clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on the rising clock edge, off during reset.
`define BBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same, with an explicit clock and active-low reset.
`define BBF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define BBF_ASSERT(lbl, prop, msg)
`define BBF_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`endif

`endif

[hw/rtl/bbf_pkg.sv]
// Types and constants of the blocked Bloom filter.
// No dependencies.
package bbf_pkg;

  localparam int ROW_BITS = 512;   // one filter block
  localparam int BIT_W    = 9;     // bit index within a block
  localparam int LANES    = 8;     // bit positions decoded per cycle

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CHECK  = 1'b1;

  // register index (paddr[2])
  localparam logic REG_NUM_HASHES    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEL,
    ST_MASK,
    ST_FIN
  } state_e;

endpackage

[hw/rtl/blocked_bloom_filter_top.sv]
// Blocked Bloom filter top level.
// Depends on bbf_pkg and assert_macros.svh.
//
// Blocked Bloom filter over MAX_BLOCKS rows of 512 bits held in one
// synchronous RAM (one read, one write port, registered read data). After
// reset the block sweeps the RAM to zero, one row per cycle, so it accepts no
// item until every row is cleared; APB writes work throughout.
// Each item is handled alone: accept, block select (hash * blocks_in_use,
// upper bits), mask build, then write-back or result. The mask is built 8 bit
// positions per cycle by stepping the double-hash index, and the row read
// overlaps that step. A check result sits in an output register, so the next
// item is taken while it waits; only a new check result waits for that
// register to drain. Every item, insert or check, consumes one batch position;
// batch_end restarts the count at 0. Registers: num_hashes at byte 0x0,
// blocks_in_use at byte 0x4; written values are clamped (hashes to
// MAX_HASHES, blocks to 1..MAX_BLOCKS).
`include "assert_macros.svh"

module blocked_bloom_filter_top #(
  parameter int MAX_BLOCKS = 2048,
  parameter int MAX_HASHES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [63:0] hash_i,
  input  logic        batch_end_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        present_o,
  output logic [31:0] batch_position_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int HCW = $clog2(MAX_HASHES + bbf_pkg::LANES + 1);
  localparam int CW  = ((HCW > 7) ? HCW : 7) + 1;
  localparam logic [6:0]  NumRst = (MAX_HASHES < 4) ? 7'(MAX_HASHES) : 7'd4;
  localparam logic [11:0] BlkRst = (MAX_BLOCKS < 2048) ? 12'(MAX_BLOCKS) : 12'd2048;
  localparam logic [BW-1:0] LastRow = BW'(MAX_BLOCKS - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [6:0]  num_q;
  logic [11:0] blocks_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= NumRst;
      blocks_q <= BlkRst;
    end else if (cfg_we) begin
      case (paddr[2])
        bbf_pkg::REG_NUM_HASHES: begin
          num_q <= (int'(pwdata[6:0]) > MAX_HASHES) ? 7'(MAX_HASHES) : pwdata[6:0];
        end
        bbf_pkg::REG_BLOCKS_IN_USE: begin
          if (pwdata[11:0] == 12'd0) begin
            blocks_q <= 12'd1;
          end else if (int'(pwdata[11:0]) > MAX_BLOCKS) begin
            blocks_q <= 12'(MAX_BLOCKS);
          end else begin
            blocks_q <= pwdata[11:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bbf_pkg::REG_NUM_HASHES:    prdata = {25'd0, num_q};
      bbf_pkg::REG_BLOCKS_IN_USE: prdata = {20'd0, blocks_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------
  bbf_pkg::state_e state_q, state_d;
  logic [BW-1:0]   clr_q;
  logic [HCW-1:0]  idx_q;
  logic            func_q;
  logic            in_acc, out_acc, out_free, mask_last, load_out;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign out_free  = !out_valid_o || !out_stall_i;
  assign mask_last = (CW'(idx_q) + CW'(bbf_pkg::LANES)) >= CW'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      bbf_pkg::ST_CLEAR: begin
        if (clr_q == LastRow) state_d = bbf_pkg::ST_IDLE;
      end
      bbf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = bbf_pkg::ST_SEL;
      end
      bbf_pkg::ST_SEL: begin
        state_d = bbf_pkg::ST_MASK;
      end
      bbf_pkg::ST_MASK: begin
        if (mask_last) state_d = bbf_pkg::ST_FIN;
      end
      bbf_pkg::ST_FIN: begin
        if (func_q == bbf_pkg::FUNC_INSERT) begin
          state_d = bbf_pkg::ST_IDLE;
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = bbf_pkg::ST_IDLE;
        end
      end
      default: state_d = bbf_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Item datapath
  // ---------------------------------------------------------------------
  logic [63:0]                   hash_q;
  logic [31:0]                   pos_q, item_pos_q;
  logic [bbf_pkg::BIT_W-1:0]     base_q, lo9_q;
  logic [BW-1:0]                 blk_q, blk_d;
  logic [75:0]                   prod;
  logic [31:0]                   sel32;
  logic [bbf_pkg::ROW_BITS-1:0]  mask_q, mask_d;
  logic [bbf_pkg::BIT_W-1:0]     lane_bit;

  // upper bits of hash * blocks_in_use; always below blocks_in_use
  assign prod  = hash_q * 76'(blocks_q);
  assign sel32 = 32'(prod[75:64]);
  assign blk_d = (sel32 > 32'(MAX_BLOCKS - 1)) ? LastRow : sel32[BW-1:0];

  // eight consecutive double-hash positions: base + lo*j, mod 512
  always_comb begin
    mask_d   = mask_q;
    lane_bit = '0;
    for (int j = 0; j < bbf_pkg::LANES; j++) begin
      lane_bit = base_q + bbf_pkg::BIT_W'(lo9_q * bbf_pkg::BIT_W'(j));
      if ((CW'(idx_q) + CW'(j)) < CW'(num_q)) mask_d[lane_bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      clr_q <= '0;
    end else begin
      if (in_acc) pos_q <= batch_end_i ? 32'd0 : pos_q + 32'd1;
      if (state_q == bbf_pkg::ST_CLEAR) clr_q <= clr_q + BW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q     <= func_i;
      hash_q     <= hash_i;
      item_pos_q <= pos_q;
      base_q     <= hash_i[32 +: bbf_pkg::BIT_W];
      lo9_q      <= hash_i[bbf_pkg::BIT_W-1:0];
      idx_q      <= '0;
      mask_q     <= '0;
    end else if (state_q == bbf_pkg::ST_MASK) begin
      mask_q <= mask_d;
      base_q <= base_q + (lo9_q << 3);
      idx_q  <= idx_q + HCW'(bbf_pkg::LANES);
    end
    if (state_q == bbf_pkg::ST_SEL) blk_q <= blk_d;
  end

  // ---------------------------------------------------------------------
  // Bit store: one 512-bit row per block
  // ---------------------------------------------------------------------
  logic [bbf_pkg::ROW_BITS-1:0] mem [MAX_BLOCKS];
  logic [bbf_pkg::ROW_BITS-1:0] rdata_q, wdata;
  logic [BW-1:0]                waddr;
  logic                         mem_we, mem_re;

  assign mem_re = (state_q == bbf_pkg::ST_MASK);
  always_comb begin
    mem_we = 1'b0;
    waddr  = blk_q;
    wdata  = rdata_q | mask_q;
    if (state_q == bbf_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
      waddr  = clr_q;
      wdata  = '0;
    end else if (state_q == bbf_pkg::ST_FIN && func_q == bbf_pkg::FUNC_INSERT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[blk_q];
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic out_valid_q, present_q;
  logic [31:0] out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      present_q <= ((rdata_q & mask_q) == mask_q);
      out_pos_q <= item_pos_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign present_o        = present_q;
  assign batch_position_o = out_pos_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BBF_ASSERT(a_acc_starts_item, in_acc |=> (state_q == bbf_pkg::ST_SEL), "accepted item not started")
  `BBF_ASSERT(a_out_from_check, (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q == bbf_pkg::ST_FIN) && $past(func_q == bbf_pkg::FUNC_CHECK)), "result without a check")
  `BBF_ASSERT(a_no_write_in_mask, (state_q == bbf_pkg::ST_MASK) |-> !mem_we, "row written while being read")

endmodule

[tb/blocked_bloom_filter_checker.sv]
`timescale 1ns / 1ps
// Checker for the blocked Bloom filter: watches the item, result and APB
// channels, keeps its own copy of the filter bits and compares lookups.
// Depends on bbf_pkg.
module blocked_bloom_filter_checker #(
  parameter int MAX_BLOCKS = 2048,
  parameter int MAX_HASHES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [63:0] hash_i,
  input  logic        batch_end_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        present_i,
  input  logic [31:0] batch_position_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          lookups_seen_o,
  output int          hits_seen_o
);

  typedef struct packed {
    logic        present;
    logic [31:0] position;
  } lookup_t;

  logic [63:0] filter_words [MAX_BLOCKS*8];
  int          hash_count;
  int          block_count;
  logic [31:0] batch_pos;
  lookup_t     lookups_due[$];

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    lookups_seen_o = 0;
    hits_seen_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: %s mismatch, got %0h, expected %0h (t=%0t)", what, got, want,
             $realtime);
    fail_count_o++;
  endtask

  // Insert sets, check tests, the double-hash bits of one 512-bit row.
  task automatic apply_item(input logic op, input logic [63:0] key, input logic last);
    logic [75:0] prod;
    int          row;
    logic [8:0]  bit_idx;
    logic        all_set;
    lookup_t     due;
    prod = 76'(key) * 76'(block_count);
    row = int'(prod[75:64]);
    if (row >= MAX_BLOCKS) row = MAX_BLOCKS - 1;
    all_set = 1'b1;
    for (int k = 0; k < hash_count; k++) begin
      bit_idx = key[8:0] * k[8:0] + key[40:32];
      if (op == bbf_pkg::FUNC_INSERT) filter_words[row*8 + bit_idx[8:6]][bit_idx[5:0]] = 1'b1;
      else if (!filter_words[row*8 + bit_idx[8:6]][bit_idx[5:0]]) all_set = 1'b0;
    end
    if (op == bbf_pkg::FUNC_CHECK) begin
      due.present  = all_set;
      due.position = batch_pos;
      lookups_due.push_back(due);
    end
    batch_pos = last ? 32'd0 : batch_pos + 32'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      for (int w = 0; w < MAX_BLOCKS*8; w++) filter_words[w] = '0;
      hash_count  = (MAX_HASHES < 4) ? MAX_HASHES : 4;
      block_count = (MAX_BLOCKS < 2048) ? MAX_BLOCKS : 2048;
      batch_pos   = '0;
      lookups_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          {bbf_pkg::REG_NUM_HASHES, 2'b00}:
            hash_count = (int'(pwdata_i[6:0]) > MAX_HASHES) ? MAX_HASHES :
                         int'(pwdata_i[6:0]);
          {bbf_pkg::REG_BLOCKS_IN_USE, 2'b00}: begin
            block_count = (pwdata_i[11:0] == 12'd0) ? 1 : int'(pwdata_i[11:0]);
            if (block_count > MAX_BLOCKS) block_count = MAX_BLOCKS;
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) apply_item(func_i, hash_i, batch_end_i);
      if (out_valid_i && !out_stall_i) begin
        lookups_seen_o++;
        if (lookups_due.size() == 0) begin
          report_mismatch("unexpected result", batch_position_i, '0);
        end else begin
          want = lookups_due.pop_front();
          if (want.present) hits_seen_o++;
          if (present_i !== want.present)
            report_mismatch("present", 32'(present_i), 32'(want.present));
          if (batch_position_i !== want.position)
            report_mismatch("batch_position", batch_position_i, want.position);
        end
      end
    end
    pending_o = lookups_due.size();
  end

endmodule

[tb/tb_blocked_bloom_filter_top.sv]
`timescale 1ns / 1ps
// Testbench top for the blocked Bloom filter: clock, reset, APB setup and
// item stimulus; the checker does all prediction and comparison.
// Depends on bbf_pkg, blocked_bloom_filter_top and blocked_bloom_filter_checker.
module tb_blocked_bloom_filter_top;

  localparam int SETTLE       = 20;      // covers the longest item (64 hashes)
  localparam int CYCLE_LIMIT  = 400000;  // clear pass + ~1000 slow items, many times over
  localparam int RANDOM_ITEMS = 125;     // per filter setting, 8 settings

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        func_i      = bbf_pkg::FUNC_INSERT;
  logic [63:0] hash_i      = '0;
  logic        batch_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        present_o;
  logic [31:0] batch_position_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int lookups_seen;
  int hits_seen;

  // stimulus bookkeeping
  int          idle_pct     = 0;  // sender: chance of an empty cycle before an item
  int          stall_pct    = 0;  // receiver: chance of stalling each cycle
  int          items_sent   = 0;
  int          checks_sent  = 0;
  int          settings_run = 0;
  int          cycle_count  = 0;
  logic [63:0] stored_keys[$];    // inserted hashes, reused so checks can hit

  blocked_bloom_filter_top dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .func_i, .hash_i, .batch_end_i,
    .out_valid_o, .out_stall_i, .present_o, .batch_position_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  blocked_bloom_filter_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .hash_i, .batch_end_i,
    .out_valid_i(out_valid_o), .out_stall_i, .present_i(present_o),
    .batch_position_i(batch_position_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending),
    .lookups_seen_o(lookups_seen), .hits_seen_o(hits_seen)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hang or a lookup that never comes back ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Present one item, with optional idle cycles first. Valid stays high
  // after acceptance so back-to-back items never drop it within a step;
  // the caller lowers it when the stream pauses.
  task automatic push_item(input logic op, input logic [63:0] key, input logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= op;
    hash_i      <= key;
    batch_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
    if (op == bbf_pkg::FUNC_CHECK) begin
      checks_sent++;
    end else begin
      stored_keys.push_back(key);
      if (stored_keys.size() > 512) void'(stored_keys.pop_front());
    end
  endtask

  // Stop sending, wait for every lookup, then let a trailing insert finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  // New filter setting, written only once the block has gone quiet. Upper
  // data bits are random: the block must ignore them. Raw values may be out
  // of range to exercise the clamps.
  task automatic set_filter(input logic [6:0] hashes, input logic [11:0] blocks);
    logic [31:0] data;
    drain();
    data = $urandom;
    data[6:0] = hashes;
    write_reg(bbf_pkg::REG_NUM_HASHES, data);
    data = $urandom;
    data[11:0] = blocks;
    write_reg(bbf_pkg::REG_BLOCKS_IN_USE, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_run++;
  endtask

  initial begin
    logic [63:0] key;
    logic [63:0] probe;
    logic        op;
    logic        last;
    int          pick;
    logic [6:0]  hashes;
    logic [11:0] blocks;
    logic [6:0]  hash_plan [8];
    logic [11:0] block_plan [8];

    hash_plan  = '{7'd8,  7'd1,  7'd64,    7'd0,  7'd3,     7'd100, 7'd0, 7'd4};
    block_plan = '{12'd64, 12'd1, 12'd2048, 12'd5, 12'd4095, 12'd0,  12'd0, 12'd2048};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset setting (4 hashes, 2048 blocks), hash extremes, a batch end.
    push_item(bbf_pkg::FUNC_INSERT, 64'd0, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, 64'd0, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, '1, 1'b0);
    push_item(bbf_pkg::FUNC_INSERT, '1, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, '1, 1'b1);

    // Zero hashes: every check reports present, inserts leave bits alone.
    set_filter(7'd0, 12'd2048);
    key = {$urandom, $urandom};
    push_item(bbf_pkg::FUNC_INSERT, key, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, key, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, {$urandom, $urandom}, 1'b0);

    // Clamps: 127 hashes saturate to 64, zero blocks become one.
    set_filter(7'd127, 12'd0);
    probe = {$urandom, $urandom};
    push_item(bbf_pkg::FUNC_INSERT, probe, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, probe, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, {$urandom, $urandom}, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, '1, 1'b0);

    // Oversized block count saturates; stored bits survive the resize.
    set_filter(7'd64, 12'd4095);
    push_item(bbf_pkg::FUNC_CHECK, 64'd0, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, '1, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, probe, 1'b0);
    key = {$urandom, $urandom};
    push_item(bbf_pkg::FUNC_INSERT, key, 1'b0);
    push_item(bbf_pkg::FUNC_CHECK, key, 1'b1);

    // Random part: mostly insert-then-lookup traffic on stored keys, some
    // lookups of fresh keys as noise. Idling pattern rotates per setting.
    for (int p = 0; p < 8; p++) begin
      hashes = hash_plan[p];
      blocks = block_plan[p];
      if (p == 6) begin
        hashes = 7'($urandom_range(127));
        blocks = 12'($urandom_range(4095));
      end
      set_filter(hashes, blocks);
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 56; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(99);
        last = ($urandom_range(5) == 0);
        if (pick < 45) begin
          op  = bbf_pkg::FUNC_INSERT;
          key = {$urandom, $urandom};
        end else if (pick < 85 && stored_keys.size() != 0) begin
          op  = bbf_pkg::FUNC_CHECK;
          key = stored_keys[$urandom_range(stored_keys.size() - 1)];
        end else begin
          op  = bbf_pkg::FUNC_CHECK;
          key = {$urandom, $urandom};
        end
        if ($urandom_range(63) == 0) key = '0;
        else if ($urandom_range(63) == 0) key = '1;
        push_item(op, key, last);
      end
    end

    drain();
    $display("run: %0d items (%0d lookups) over %0d filter settings,", items_sent, checks_sent,
             settings_run + 1);
    $display("run: %0d results compared, %0d expected present, %0d mismatches", lookups_seen,
             hits_seen, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[blocked_bloom_filter_top.f]
+incdir+hw/rtl
hw/rtl/bbf_pkg.sv
hw/rtl/blocked_bloom_filter_top.sv
tb/blocked_bloom_filter_checker.sv
tb/tb_blocked_bloom_filter_top.sv
